[hw/rtl/smgd_pkg.sv]
// Shared types, codes and fixed-point constants for the steering motor guard.
// Used by every module of the block; depends on nothing else.

package smgd_pkg;

	// Input beat operation codes.
	localparam logic [1:0] OP_RUN        = 2'd0;
	localparam logic [1:0] OP_SET_POWER  = 2'd1;
	localparam logic [1:0] OP_SET_ENABLE = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_END_STOP    = 3'd0;
	localparam logic [2:0] REG_BRAKE_START = 3'd1;
	localparam logic [2:0] REG_BRAKE_STOP  = 3'd2;
	localparam logic [2:0] REG_BRAKE_POWER = 3'd3;
	localparam logic [2:0] REG_DEAD_TIME   = 3'd4;
	localparam logic [2:0] REG_POWER_SCALE = 3'd5;
	localparam logic [2:0] REG_MIN_COMMAND = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_RUNNING  = 3'd0,
		ST_DEADTIME = 3'd1,
		ST_DISABLED = 3'd2,
		ST_FAULT    = 3'd3,
		ST_ACCEPTED = 3'd4,
		ST_REJECTED = 3'd5
	} status_t;

	// Guard codes.
	localparam logic [1:0] GUARD_NONE    = 2'd0;
	localparam logic [1:0] GUARD_POS     = 2'd1;
	localparam logic [1:0] GUARD_NEG     = 2'd2;
	localparam logic [1:0] GUARD_NOT_CAL = 2'd3;

	// Angle reading that flags a sensor fault.
	localparam logic signed [15:0] FAULT_ANGLE = 16'sd666;

	// Division by 100 as a multiply by 5243 and a right shift of 19. Exact for
	// every product below 2^15, which covers both uses here.
	localparam int RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	// Duty factor: 255 / 100 in the same fixed-point form.
	localparam logic [20:0] DUTY_K = 21'd1336965;
	localparam logic [6:0] SCALE_RESET = 7'd100;
	// Reset value of the combined scale factor, 100 * 5243.
	localparam logic [19:0] SCALE_K_RESET = 20'd524300;

	localparam logic [7:0] DUTY_MAX = 8'd255;

	// Configuration register contents, with the derived scale factor.
	typedef struct packed {
		logic [14:0] end_stop;
		logic [14:0] brake_start;
		logic [14:0] brake_stop;
		logic [6:0]  brake_power;
		logic [15:0] dead_time;
		logic [6:0]  min_command;
		logic [19:0] scale_k;
	} cfg_t;

	// One input beat.
	typedef struct packed {
		logic [1:0]         op;
		logic signed [7:0]  power_command;
		logic               enable_value;
		logic signed [15:0] steer_angle;
		logic               not_calibrated;
		logic [31:0]        now_ms;
	} item_t;

	// Bridge controller state.
	typedef struct packed {
		logic              enabled;
		logic signed [7:0] target;
		logic signed [7:0] applied;
		logic              dir;
		logic [7:0]        duty;
		logic [31:0]       dead_start;
	} state_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] pwm_duty;
		logic       direction;
		status_t    status;
		logic [1:0] guard;
		logic       braking;
	} result_t;

endpackage

[hw/rtl/smgd_cfg_regs.sv]
// Configuration register bank of the steering motor guard.
// Depends on smgd_pkg for the register indexes and the cfg_t bundle.

module smgd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [smgd_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [smgd_pkg::CFG_DATA_W-1:0]     wr_data,
	output smgd_pkg::cfg_t                      cfg
);
	import smgd_pkg::*;

	cfg_t cfg_q;

	// Register writes; a power scale write also refreshes the fixed-point factor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_stop    <= '0;
			cfg_q.brake_start <= '0;
			cfg_q.brake_stop  <= '0;
			cfg_q.brake_power <= '0;
			cfg_q.dead_time   <= '0;
			cfg_q.min_command <= '0;
			cfg_q.scale_k     <= SCALE_K_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_END_STOP:    cfg_q.end_stop    <= wr_data[14:0];
				REG_BRAKE_START: cfg_q.brake_start <= wr_data[14:0];
				REG_BRAKE_STOP:  cfg_q.brake_stop  <= wr_data[14:0];
				REG_BRAKE_POWER: cfg_q.brake_power <= wr_data[6:0];
				REG_DEAD_TIME:   cfg_q.dead_time   <= wr_data;
				REG_POWER_SCALE: cfg_q.scale_k     <= 20'(wr_data[6:0]) * 20'(RECIP_100);
				REG_MIN_COMMAND: cfg_q.min_command <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/smgd_step.sv]
// Single-pass step logic: next controller state and result for one beat.
// Depends on smgd_pkg; purely combinational, registered by the top level.

module smgd_step (
	input  smgd_pkg::item_t   item,
	input  smgd_pkg::state_t  cur,
	input  smgd_pkg::cfg_t    cfg,
	output smgd_pkg::state_t  nxt,
	output smgd_pkg::result_t res
);
	import smgd_pkg::*;

	logic [7:0]         cmd_abs;
	logic               cmd_ok;
	logic [6:0]         cmd_mag;
	logic [26:0]        scaled;
	logic [6:0]         scaled_mag;
	logic signed [7:0]  cmd_target;

	logic               en_next;
	logic signed [16:0] angle_x;
	logic [16:0]        angle_mag;
	logic signed [15:0] lim_pos;
	logic signed [15:0] lim_neg;
	logic               above;
	logic               below;
	logic               in_window;
	logic signed [7:0]  brake_target;
	logic signed [7:0]  tgt;

	logic               app_pos;
	logic               app_neg;
	logic               tgt_pos;
	logic               tgt_neg;
	logic               sign_change;
	logic [31:0]        elapsed;
	logic               dead_done;

	logic [7:0]         tgt_abs;
	logic [27:0]        duty_prod;
	logic [8:0]         duty_full;
	logic [7:0]         duty_val;

	// Power command: range check, dead band and percent scaling.
	always_comb begin
		cmd_abs    = item.power_command[7] ? 8'(-item.power_command) : item.power_command;
		cmd_ok     = (item.power_command >= -8'sd100) && (item.power_command <= 8'sd100);
		cmd_mag    = (cmd_abs[6:0] <= cfg.min_command) ? 7'd0 : cmd_abs[6:0];
		scaled     = 27'(cmd_mag) * 27'(cfg.scale_k);
		scaled_mag = scaled[RECIP_SHIFT+6:RECIP_SHIFT];
		cmd_target = item.power_command[7] ? -$signed({1'b0, scaled_mag})
		                                   : $signed({1'b0, scaled_mag});
	end

	// End-stop and calibration guard with the reverse-brake window.
	always_comb begin
		en_next   = (item.op == OP_SET_ENABLE) ? item.enable_value : cur.enabled;
		angle_x   = 17'(item.steer_angle);
		angle_mag = item.steer_angle[15] ? 17'(-angle_x) : 17'(angle_x);
		lim_pos   = $signed({1'b0, cfg.end_stop});
		lim_neg   = -lim_pos;
		above     = item.steer_angle > lim_pos;
		below     = item.steer_angle < lim_neg;
		in_window = (angle_mag > 17'(cfg.brake_start)) && (angle_mag < 17'(cfg.brake_stop));
		if (item.steer_angle > 16'sd0) begin
			brake_target = $signed({1'b0, cfg.brake_power});
		end else if (item.steer_angle < 16'sd0) begin
			brake_target = -$signed({1'b0, cfg.brake_power});
		end else begin
			brake_target = 8'sd0;
		end
		tgt = cur.target;
		if (above || below || item.not_calibrated) begin
			tgt = in_window ? brake_target : 8'sd0;
		end
	end

	// Direction change detection, dead time and duty scaling.
	always_comb begin
		app_pos     = !cur.applied[7] && (cur.applied != 8'sd0);
		app_neg     = cur.applied[7];
		tgt_pos     = !tgt[7] && (tgt != 8'sd0);
		tgt_neg     = tgt[7];
		sign_change = (app_pos != tgt_pos) || (app_neg != tgt_neg);
		elapsed     = item.now_ms - cur.dead_start;
		dead_done   = elapsed >= 32'(cfg.dead_time);
		tgt_abs     = tgt[7] ? 8'(-tgt) : 8'(tgt);
		duty_prod   = 28'(tgt_abs) * 28'(DUTY_K);
		duty_full   = duty_prod[RECIP_SHIFT+8:RECIP_SHIFT];
		duty_val    = (duty_full > 9'(DUTY_MAX)) ? DUTY_MAX : duty_full[7:0];
	end

	// Decision tree for one beat.
	always_comb begin
		nxt         = cur;
		res.guard   = GUARD_NONE;
		res.braking = 1'b0;
		res.status  = ST_RUNNING;
		if (item.op == OP_SET_POWER) begin
			if (cmd_ok) begin
				nxt.target = cmd_target;
				res.status = ST_ACCEPTED;
			end else begin
				res.status = ST_REJECTED;
			end
		end else if (item.steer_angle == FAULT_ANGLE) begin
			nxt.enabled = 1'b0;
			nxt.target  = 8'sd0;
			nxt.applied = 8'sd0;
			nxt.duty    = '0;
			res.status  = ST_FAULT;
		end else if (!en_next) begin
			nxt.enabled = 1'b0;
			nxt.target  = 8'sd0;
			nxt.applied = 8'sd0;
			nxt.duty    = '0;
			res.status  = ST_DISABLED;
		end else begin
			nxt.enabled = 1'b1;
			nxt.target  = tgt;
			if (above) begin
				res.guard = GUARD_POS;
			end else if (below) begin
				res.guard = GUARD_NEG;
			end else if (item.not_calibrated) begin
				res.guard = GUARD_NOT_CAL;
			end
			res.braking = (above || below || item.not_calibrated) && in_window;
			if (sign_change) begin
				nxt.dir        = tgt_pos;
				nxt.duty       = '0;
				nxt.dead_start = item.now_ms;
				nxt.applied    = tgt;
				res.status     = ST_DEADTIME;
			end else if (dead_done) begin
				nxt.applied = tgt;
				nxt.duty    = duty_val;
				res.status  = ST_RUNNING;
			end else begin
				res.status = ST_DEADTIME;
			end
		end
		res.pwm_duty  = nxt.duty;
		res.direction = nxt.dir;
	end

endmodule

[hw/rtl/steer_motor_guard_deadtime_unit.sv]
// Top level of the steering motor H-bridge guard with dead time.
// Depends on smgd_pkg, smgd_cfg_regs and smgd_step.
//
// Usage:
// The item channel (item_valid / item_stall) carries one command or run beat:
// op 0 runs a control step, op 1 loads a power command, op 2 writes the motor
// enable and then runs a step. Every accepted beat yields exactly one result
// beat on the result channel (result_valid / result_stall) with the duty,
// direction line, status, guard code and braking flag.
// The accepting edge loads the input register; the beat moves into the result
// register, raising result_valid, once that is free. Throughput is one beat per
// clock while result_stall is low; the controller state is updated as each beat
// moves on, so back-to-back beats see each other's effects with no bubble.
// While the receiver stalls a full result register, the input register holds
// its beat and item_stall rises once it is occupied; nothing is dropped.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while no beat is in flight.
// Asynchronous reset clears the controller state, both valid flags and the
// registers to their defaults (power scale 100, everything else zero).

module steer_motor_guard_deadtime_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [smgd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [smgd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       op,
	input  logic signed [7:0]                power_command,
	input  logic                             enable_value,
	input  logic signed [15:0]               steer_angle,
	input  logic                             not_calibrated,
	input  logic [31:0]                      now_ms,
	// Result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [7:0]                       pwm_duty,
	output logic                             direction,
	output logic [2:0]                       status,
	output logic [1:0]                       guard,
	output logic                             braking
);
	import smgd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    item_accept;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	smgd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the result register frees up when empty or when taken.
	assign advance     = !valid_s2 || !result_stall;
	assign item_stall  = valid_s1 && !advance;
	assign item_accept = item_valid && !item_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1.op             <= op;
			item_s1.power_command  <= power_command;
			item_s1.enable_value   <= enable_value;
			item_s1.steer_angle    <= steer_angle;
			item_s1.not_calibrated <= not_calibrated;
			item_s1.now_ms         <= now_ms;
		end
	end

	// Step logic.
	smgd_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Controller state, updated as each beat moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign pwm_duty     = res_s2.pwm_duty;
	assign direction    = res_s2.direction;
	assign status       = res_s2.status;
	assign guard        = res_s2.guard;
	assign braking      = res_s2.braking;

	// A fault or disabled result always reports the bridge switched off.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status == ST_FAULT || res_s2.status == ST_DISABLED)
		|-> res_s2.pwm_duty == 8'd0)
	else $error("duty not zero on a fault or disabled result");

	// Guard codes only appear on control steps that reach the bridge.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.guard != GUARD_NONE
		|-> (res_s2.status == ST_RUNNING || res_s2.status == ST_DEADTIME))
	else $error("guard reported on a step that does not drive the bridge");

	// Braking is only ever applied under an active guard.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.braking |-> res_s2.guard != GUARD_NONE)
	else $error("braking without a guard");

	// A fault-angle run beat leaves the motor disabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && item_s1.op != OP_SET_POWER
		&& item_s1.steer_angle == FAULT_ANGLE
		|=> !state_q.enabled)
	else $error("motor still enabled after a sensor fault");

	// A direction change always starts from zero duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && state_nxt.dir != state_q.dir
		|=> state_q.duty == 8'd0)
	else $error("direction changed with duty applied");

endmodule

[tb/sv/steer_motor_guard_deadtime_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the steering motor H-bridge guard with dead time.
// Depends on smgd_pkg and steer_motor_guard_deadtime_unit; a scoreboard class
// predicts every result beat and random pacing exercises both handshakes.

module steer_motor_guard_deadtime_unit_tb;

	import smgd_pkg::*;

	// Selector three is decoded as a run step, like OP_RUN.
	localparam logic [1:0] OP_RUN_ALT = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BEATS_PER_PHASE = 180;
	localparam int MAX_REPORTS = 100;

	// Predicts the bridge controller and checks result beats in order.
	class bridge_guard_scoreboard;
		logic [14:0] end_stop, brake_start, brake_stop;
		logic [6:0]  brake_power, power_scale, min_command;
		logic [15:0] dead_time;
		bit          enabled;
		int          target, applied;
		bit          dir_line;
		logic [7:0]  duty;
		logic [31:0] dead_start;
		result_t     results_due[$];
		int unsigned mismatches;
		int unsigned reports;

		function new();
			end_stop = '0;
			brake_start = '0;
			brake_stop = '0;
			brake_power = '0;
			dead_time = '0;
			power_scale = SCALE_RESET;
			min_command = '0;
			enabled = 1'b0;
			target = 0;
			applied = 0;
			dir_line = 1'b0;
			duty = '0;
			dead_start = '0;
			mismatches = 0;
			reports = 0;
		endfunction

		function void write_register(logic [2:0] index, logic [15:0] data);
			case (index)
				REG_END_STOP:    end_stop = data[14:0];
				REG_BRAKE_START: brake_start = data[14:0];
				REG_BRAKE_STOP:  brake_stop = data[14:0];
				REG_BRAKE_POWER: brake_power = data[6:0];
				REG_DEAD_TIME:   dead_time = data;
				REG_POWER_SCALE: power_scale = data[6:0];
				REG_MIN_COMMAND: min_command = data[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function int sign_of(int v);
			if (v > 0)
				return 1;
			if (v < 0)
				return -1;
			return 0;
		endfunction

		// Duty is |power| * 255 / 100, saturated at full scale.
		function logic [7:0] duty_of(int p);
			int m;
			m = (p < 0) ? -p : p;
			m = m * 255 / 100;
			return (m > 255) ? 8'd255 : m[7:0];
		endfunction

		// Works out the result of one accepted beat and updates the state.
		function void predict_bridge_beat(item_t it);
			result_t r;
			int cmd, ang, mag, lim;
			logic [31:0] elapsed;
			r = '0;
			r.guard = GUARD_NONE;
			r.braking = 1'b0;
			ang = $signed(it.steer_angle);
			if (it.op == OP_SET_POWER) begin
				cmd = $signed(it.power_command);
				if (cmd >= -100 && cmd <= 100) begin
					mag = (cmd < 0) ? -cmd : cmd;
					if (mag <= int'(min_command))
						cmd = 0;
					target = cmd * int'(power_scale) / 100;
					r.status = ST_ACCEPTED;
				end else begin
					r.status = ST_REJECTED;
				end
			end else begin
				if (it.op == OP_SET_ENABLE)
					enabled = it.enable_value;
				if (it.steer_angle == FAULT_ANGLE) begin
					enabled = 1'b0;
					target = 0;
					applied = 0;
					duty = '0;
					r.status = ST_FAULT;
				end else if (!enabled) begin
					target = 0;
					applied = 0;
					duty = '0;
					r.status = ST_DISABLED;
				end else begin
					// End-stop and calibration guard, with the reverse-brake window.
					lim = int'(end_stop);
					if (ang > lim || ang < -lim || it.not_calibrated) begin
						mag = (ang < 0) ? -ang : ang;
						r.guard = (ang > lim) ? GUARD_POS : ((ang < -lim) ? GUARD_NEG : GUARD_NOT_CAL);
						target = 0;
						if (mag > int'(brake_start) && mag < int'(brake_stop)) begin
							target = int'(brake_power) * sign_of(ang);
							r.braking = 1'b1;
						end
					end
					// A sign change restarts the dead time with the bridge off.
					elapsed = it.now_ms - dead_start;
					if (sign_of(applied) != sign_of(target)) begin
						dir_line = (target > 0);
						duty = '0;
						dead_start = it.now_ms;
						applied = target;
						r.status = ST_DEADTIME;
					end else if (elapsed >= {16'd0, dead_time}) begin
						applied = target;
						duty = duty_of(applied);
						r.status = ST_RUNNING;
					end else begin
						r.status = ST_DEADTIME;
					end
				end
			end
			r.pwm_duty = duty;
			r.direction = dir_line;
			results_due.push_back(r);
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				if (reports < MAX_REPORTS)
					$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
				reports++;
			end
		endfunction

		function void check_bridge_beat(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no prediction waiting (duty %0d, status %0d)",
					$time, got.pwm_duty, got.status);
				return;
			end
			want = results_due.pop_front();
			report("pwm_duty", want.pwm_duty, got.pwm_duty);
			report("direction", want.direction, got.direction);
			report("status", want.status, got.status);
			report("guard", want.guard, got.guard);
			report("braking", want.braking, got.braking);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic [1:0]             op = '0;
	logic signed [7:0]      power_command = '0;
	logic                   enable_value = 1'b0;
	logic signed [15:0]     steer_angle = '0;
	logic                   not_calibrated = 1'b0;
	logic [31:0]            now_ms = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [7:0]             pwm_duty;
	logic                   direction;
	logic [2:0]             status;
	logic [1:0]             guard;
	logic                   braking;

	bridge_guard_scoreboard sb;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	logic [31:0] stamp_ms = '0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	logic [3:0]  stall_phase = '0;

	steer_motor_guard_deadtime_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.op             (op),
		.power_command  (power_command),
		.enable_value   (enable_value),
		.steer_angle    (steer_angle),
		.not_calibrated (not_calibrated),
		.now_ms         (now_ms),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pwm_duty       (pwm_duty),
		.direction      (direction),
		.status         (status),
		.guard          (guard),
		.braking        (braking)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver switches between no stalls, light and heavy random stalls
	// and a square wave, each for a random stretch.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: result_stall <= stall_phase[2];
		endcase
	end

	// Every result beat taken by the receiver is checked.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.pwm_duty = pwm_duty;
			got.direction = direction;
			got.status = status_t'(status);
			got.guard = guard;
			got.braking = braking;
			sb.check_bridge_beat(got);
		end
	end

	function automatic item_t make_beat(logic [1:0] sel, int cmd, bit en, int ang, bit notcal,
			logic [31:0] now);
		item_t it;
		it.op = sel;
		it.power_command = cmd[7:0];
		it.enable_value = en;
		it.steer_angle = ang[15:0];
		it.not_calibrated = notcal;
		it.now_ms = now;
		return it;
	endfunction

	// Mostly well-formed beats aimed at the guard limits and the brake window,
	// with a running time stamp; a small share is pure noise.
	function automatic item_t random_item();
		item_t it;
		int mag, ang, cmd, pick;
		it = '0;
		it.power_command = 8'($urandom);
		it.enable_value = 1'($urandom);
		it.not_calibrated = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 99) < 8) begin
			it.op = 2'($urandom);
			it.steer_angle = 16'($urandom);
			it.not_calibrated = 1'($urandom);
			it.now_ms = $urandom;
			return it;
		end
		// Time moves on, now and then past the dead time or across the wrap.
		if ($urandom_range(0, 149) == 0)
			stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
		else if ($urandom_range(0, 9) == 0)
			stamp_ms = stamp_ms + sb.dead_time + $urandom_range(0, 2);
		else
			stamp_ms = stamp_ms + $urandom_range(0, sb.dead_time / 4 + 2);
		it.now_ms = stamp_ms;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			it.op = OP_SET_ENABLE;
			it.enable_value = ($urandom_range(0, 6) != 0);
		end else if (pick < 50) begin
			it.op = OP_SET_POWER;
			if ($urandom_range(0, 11) == 0)
				cmd = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(101, 128));
			else
				cmd = int'($urandom_range(0, 200)) - 100;
			it.power_command = cmd[7:0];
		end else if (pick < 56) begin
			it.op = OP_RUN_ALT;
		end else begin
			it.op = OP_RUN;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mag = $urandom_range(0, sb.end_stop);
			4, 5, 6: mag = (sb.brake_start <= sb.brake_stop) ?
				$urandom_range(sb.brake_start, sb.brake_stop) :
				$urandom_range(sb.brake_stop, sb.brake_start);
			7: mag = sb.end_stop + $urandom_range(0, 2);
			8: mag = $urandom_range(0, 32767);
			default: mag = -1;
		endcase
		if (mag < 0) begin
			case ($urandom_range(0, 4))
				0: ang = FAULT_ANGLE;
				1: ang = -int'(FAULT_ANGLE);
				2: ang = 32767;
				3: ang = -32768;
				default: ang = 0;
			endcase
		end else begin
			if (mag > 32767)
				mag = 32767;
			ang = $urandom_range(0, 1) ? -mag : mag;
		end
		it.steer_angle = ang[15:0];
		return it;
	endfunction

	// The sender runs in bursts; between bursts it may drop valid for a while.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_beat(input item_t it);
		item_valid <= 1'b1;
		op <= it.op;
		power_command <= it.power_command;
		enable_value <= it.enable_value;
		steer_angle <= it.steer_angle;
		not_calibrated <= it.not_calibrated;
		now_ms <= it.now_ms;
		do @(posedge clk); while (item_stall);
		sb.predict_bridge_beat(it);
		pace_sender();
	endtask

	// Holds the sender off until every predicted result has been taken.
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Writes all seven registers in index order, valid held high throughout.
	task automatic apply_settings(input logic [15:0] stop_angle, win_lo, win_hi, brake_mag,
			dead_ms, scale_pct, dead_band);
		logic [15:0] values [7];
		logic [2:0]  indexes [7];
		values = '{stop_angle, win_lo, win_hi, brake_mag, dead_ms, scale_pct, dead_band};
		indexes = '{REG_END_STOP, REG_BRAKE_START, REG_BRAKE_STOP, REG_BRAKE_POWER,
			REG_DEAD_TIME, REG_POWER_SCALE, REG_MIN_COMMAND};
		for (int k = 0; k < 7; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= indexes[k];
			cfg_data <= values[k];
			do @(posedge clk); while (!cfg_ready);
			sb.write_register(indexes[k], values[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random register values, sometimes above the nominal range, with stray
	// upper bits that the block is expected to ignore.
	task automatic random_settings();
		logic [15:0] junk, stop_angle, win_lo, win_hi;
		junk = $urandom_range(0, 1) ? 16'h0 : 16'($urandom);
		stop_angle = 16'(($urandom_range(0, 3) == 0) ?
			$urandom_range(0, 32767) : $urandom_range(0, 3000));
		win_lo = 16'($urandom_range(0, 5000));
		win_hi = 16'(win_lo + $urandom_range(0, 4000));
		apply_settings(stop_angle | (junk & 16'h8000), win_lo | (junk & 16'h8000),
			win_hi | (junk & 16'h8000),
			16'(($urandom_range(0, 4) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100))
				| (junk & 16'hFF80),
			16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 60)),
			16'(($urandom_range(0, 4) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100))
				| (junk & 16'hFF80),
			16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30))
				| (junk & 16'hFF80));
	endtask

	task automatic run_random(input int count);
		repeat (count) begin
			if ($urandom_range(0, 299) == 0)
				drain();
			send_beat(random_item());
		end
	endtask

	// Main sequence: directed beats at reset values and one setting, then
	// random phases under extreme and random settings.
	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled block, selector three, command range and rejection.
		send_beat(make_beat(OP_RUN, 0, 0, 0, 0, 32'd0));
		send_beat(make_beat(OP_RUN_ALT, 0, 0, 0, 0, 32'd0));
		send_beat(make_beat(OP_SET_POWER, 100, 0, 0, 0, 32'd0));
		send_beat(make_beat(OP_SET_POWER, 101, 0, 0, 0, 32'd0));
		send_beat(make_beat(OP_SET_POWER, -128, 0, 0, 0, 32'd0));
		// Enable, full reverse power and a dead time started just below the time wrap.
		send_beat(make_beat(OP_SET_ENABLE, 0, 1, 0, 0, 32'd10));
		send_beat(make_beat(OP_RUN, 0, 0, 0, 0, 32'd10));
		send_beat(make_beat(OP_SET_POWER, -100, 0, 0, 0, 32'd10));
		send_beat(make_beat(OP_RUN, 0, 0, 0, 0, 32'hFFFF_FFF0));
		send_beat(make_beat(OP_RUN, 0, 0, 0, 0, 32'hFFFF_FFFF));
		// Guard codes, sensor fault and disable.
		send_beat(make_beat(OP_RUN, 0, 0, 1, 0, 32'd0));
		send_beat(make_beat(OP_RUN, 0, 0, -32768, 0, 32'd5));
		send_beat(make_beat(OP_RUN, 0, 0, 0, 1, 32'd6));
		send_beat(make_beat(OP_RUN, 0, 0, FAULT_ANGLE, 0, 32'd7));
		send_beat(make_beat(OP_SET_ENABLE, 0, 0, 0, 0, 32'd8));
		send_beat(make_beat(OP_SET_POWER, 127, 0, 0, 0, 32'd9));
		drain();

		// Brake window 1000..3000, oversized power and scale, dead band of 5.
		apply_settings(16'd1000, 16'd1000, 16'd3000, 16'd127, 16'd20, 16'd127, 16'd5);
		send_beat(make_beat(OP_SET_ENABLE, 0, 1, 0, 0, 32'd100));
		send_beat(make_beat(OP_SET_POWER, 5, 0, 0, 0, 32'd100));
		send_beat(make_beat(OP_SET_POWER, 100, 0, 0, 0, 32'd100));
		send_beat(make_beat(OP_RUN, 0, 0, 500, 0, 32'd100));
		send_beat(make_beat(OP_RUN, 0, 0, 500, 0, 32'd110));
		send_beat(make_beat(OP_RUN, 0, 0, 500, 0, 32'd120));
		send_beat(make_beat(OP_RUN, 0, 0, 2000, 0, 32'd130));
		send_beat(make_beat(OP_RUN, 0, 0, -2000, 0, 32'd140));
		send_beat(make_beat(OP_RUN, 0, 0, 3000, 0, 32'd170));
		stamp_ms = 32'd200;
		run_random(BEATS_PER_PHASE);
		drain();

		// Widest limits, no dead time, largest power and scale.
		apply_settings(16'h7FFF, 16'h0000, 16'h7FFF, 16'h007F, 16'h0000, 16'h007F, 16'h0000);
		run_random(BEATS_PER_PHASE);
		drain();

		// Tightest limits, longest dead time, zero scale, widest dead band.
		apply_settings(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h007F);
		run_random(BEATS_PER_PHASE);
		drain();

		repeat (4) begin
			random_settings();
			run_random(BEATS_PER_PHASE);
			drain();
		end

		repeat (6) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[steer_motor_guard_deadtime_unit.f]
hw/rtl/smgd_pkg.sv
hw/rtl/smgd_cfg_regs.sv
hw/rtl/smgd_step.sv
hw/rtl/steer_motor_guard_deadtime_unit.sv
tb/sv/steer_motor_guard_deadtime_unit_tb.sv
